>>> rtl/hc2_pkg.sv
`default_nettype none

package hc2_pkg;

  // Default alphabet size.
  localparam int MODULUS_DEF = 26;

  // Width of a letter, a key entry and the configuration data.
  localparam int LETTER_W = 5;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_R0C0 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_R0C1 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_R1C0 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_R1C1 = 2'd3;

  // Ciphertext item: one letter pair.
  typedef struct packed {
    logic [LETTER_W-1:0] cipher_first;
    logic [LETTER_W-1:0] cipher_second;
    logic                last_pair_in;
  } cipher_t;

  // Plaintext item: one letter pair and status.
  typedef struct packed {
    logic [LETTER_W-1:0] plain_first;
    logic [LETTER_W-1:0] plain_second;
    logic                key_not_invertible;
    logic                last_pair_out;
  } plain_t;

endpackage

`default_nettype wire

>>> rtl/hc2_stream_if.sv
`default_nettype none

// Valid/ready stream carrying one item of type T per transfer.
interface hc2_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/hill_cipher_2x2_decrypt.sv
`default_nettype none

// 2x2 Hill-cipher decryptor. Each item on cipher is one ciphertext letter pair; one item
// per pair comes out on plain. The 2x2 key is loaded through cfg_we/cfg_index/cfg_data
// (indexes 0..3 are r0c0, r0c1, r1c0, r1c1; reset key is the identity) and must only be
// changed while no item is in flight. Everything derived from the key (determinant, its
// inverse from a constant table, the inverse matrix) is recomputed for every pair inside a
// nine-stage pipeline, so the block takes one item per clock unless plain stalls it; a
// result is presented on plain from the stage-9 output register. Each stage has its own
// valid bit and is held while it is full and the stage after it cannot load, so
// back-pressure on plain stalls the pipe without losing items.
// When the key determinant has no inverse modulo MODULUS, key_not_invertible is set and
// both letters are zero. Letters and key values above MODULUS-1 are reduced first.
module hill_cipher_2x2_decrypt #(
  parameter int MODULUS = hc2_pkg::MODULUS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [hc2_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [hc2_pkg::LETTER_W-1:0]   cfg_data,
  hc2_stream_if.sink                          cipher,
  hc2_stream_if.source                        plain
);
  import hc2_pkg::*;

  // Residue width, product width, and width of a sum of two products.
  localparam int RW = (MODULUS > 1) ? $clog2(MODULUS) : 1;
  localparam int PW = 2 * RW;
  localparam int DW = PW + 1;
  localparam int LW = RW + LETTER_W;
  localparam int NS = 9;
  localparam logic [DW-1:0] MSQ = DW'(MODULUS * MODULUS);

  // Reduces a 5-bit value modulo MODULUS by conditional subtraction.
  function automatic logic [RW-1:0] red_small(input logic [LETTER_W-1:0] x);
    logic [LW-1:0] r;
    r = LW'(x);
    for (int s = LETTER_W - 1; s >= 0; s--) begin
      if (r >= (LW'(MODULUS) << s)) begin
        r = r - (LW'(MODULUS) << s);
      end
    end
    return RW'(r);
  endfunction

  // Reduces a value below 2*MODULUS^2 modulo MODULUS.
  function automatic logic [RW-1:0] red_wide(input logic [DW-1:0] x);
    logic [DW-1:0] r;
    r = x;
    for (int s = RW; s >= 0; s--) begin
      if (r >= (DW'(MODULUS) << s)) begin
        r = r - (DW'(MODULUS) << s);
      end
    end
    return RW'(r);
  endfunction

  // Negation modulo MODULUS of a reduced residue.
  function automatic logic [RW-1:0] neg_res(input logic [RW-1:0] x);
    return (x == '0) ? '0 : RW'(MODULUS) - x;
  endfunction

  // Inverse of d modulo MODULUS, zero where none exists (elaboration only).
  function automatic logic [RW-1:0] inv_of(input int d);
    logic [RW-1:0] res;
    res = '0;
    for (int x = MODULUS - 1; x >= 1; x--) begin
      if ((d * x) % MODULUS == 1) begin
        res = RW'(x);
      end
    end
    return res;
  endfunction

  // Constant inverse table indexed by the reduced determinant.
  logic [RW-1:0] inv_tab [MODULUS];
  for (genvar g = 0; g < MODULUS; g++) begin : g_inv
    assign inv_tab[g] = inv_of(g);
  end

  // Key registers.
  logic [LETTER_W-1:0] key_r0c0;
  logic [LETTER_W-1:0] key_r0c1;
  logic [LETTER_W-1:0] key_r1c0;
  logic [LETTER_W-1:0] key_r1c1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_r0c0 <= LETTER_W'(1);
      key_r0c1 <= '0;
      key_r1c0 <= '0;
      key_r1c1 <= LETTER_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KEY_R0C0: key_r0c0 <= cfg_data;
        REG_KEY_R0C1: key_r0c1 <= cfg_data;
        REG_KEY_R1C0: key_r1c0 <= cfg_data;
        REG_KEY_R1C1: key_r1c1 <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipeline control: a stage loads when it is empty or the stage after it loads.
  logic [NS:1] v;
  logic [NS:1] ld;

  always_comb begin
    ld[NS] = !v[NS] || plain.ready;
    for (int k = NS - 1; k >= 1; k--) begin
      ld[k] = !v[k] || ld[k+1];
    end
  end

  assign cipher.ready = ld[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (ld[1]) begin
        v[1] <= cipher.valid;
      end
      for (int k = 2; k <= NS; k++) begin
        if (ld[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  // Stage 1: reduce key entries and letters.
  logic [RW-1:0] s1_a, s1_b, s1_c, s1_d, s1_c1, s1_c2;
  logic          s1_last;

  always_ff @(posedge clk) begin
    if (ld[1] && cipher.valid) begin
      s1_a    <= red_small(key_r0c0);
      s1_b    <= red_small(key_r0c1);
      s1_c    <= red_small(key_r1c0);
      s1_d    <= red_small(key_r1c1);
      s1_c1   <= red_small(cipher.data.cipher_first);
      s1_c2   <= red_small(cipher.data.cipher_second);
      s1_last <= cipher.data.last_pair_in;
    end
  end

  // Stage 2: determinant products.
  logic [PW-1:0] s2_ad, s2_bc;
  logic [RW-1:0] s2_a, s2_b, s2_c, s2_d, s2_c1, s2_c2;
  logic          s2_last;

  always_ff @(posedge clk) begin
    if (ld[2] && v[1]) begin
      s2_ad   <= PW'(s1_a) * PW'(s1_d);
      s2_bc   <= PW'(s1_b) * PW'(s1_c);
      s2_a    <= s1_a;
      s2_b    <= s1_b;
      s2_c    <= s1_c;
      s2_d    <= s1_d;
      s2_c1   <= s1_c1;
      s2_c2   <= s1_c2;
      s2_last <= s1_last;
    end
  end

  // Stage 3: ad - bc kept nonnegative by adding MODULUS squared.
  logic [DW-1:0] s3_det_raw;
  logic [RW-1:0] s3_a, s3_b, s3_c, s3_d, s3_c1, s3_c2;
  logic          s3_last;

  always_ff @(posedge clk) begin
    if (ld[3] && v[2]) begin
      s3_det_raw <= DW'(s2_ad) + MSQ - DW'(s2_bc);
      s3_a       <= s2_a;
      s3_b       <= s2_b;
      s3_c       <= s2_c;
      s3_d       <= s2_d;
      s3_c1      <= s2_c1;
      s3_c2      <= s2_c2;
      s3_last    <= s2_last;
    end
  end

  // Stage 4: reduce the determinant.
  logic [RW-1:0] s4_det;
  logic [RW-1:0] s4_a, s4_b, s4_c, s4_d, s4_c1, s4_c2;
  logic          s4_last;

  always_ff @(posedge clk) begin
    if (ld[4] && v[3]) begin
      s4_det  <= red_wide(s3_det_raw);
      s4_a    <= s3_a;
      s4_b    <= s3_b;
      s4_c    <= s3_c;
      s4_d    <= s3_d;
      s4_c1   <= s3_c1;
      s4_c2   <= s3_c2;
      s4_last <= s3_last;
    end
  end

  // Stage 5: inverse determinant from the table and the adjugate.
  logic [RW-1:0] s5_inv;
  logic          s5_bad;
  logic [RW-1:0] s5_j00, s5_j01, s5_j10, s5_j11, s5_c1, s5_c2;
  logic          s5_last;

  always_ff @(posedge clk) begin
    if (ld[5] && v[4]) begin
      s5_inv  <= inv_tab[s4_det];
      s5_bad  <= (inv_tab[s4_det] == '0);
      s5_j00  <= s4_d;
      s5_j01  <= neg_res(s4_b);
      s5_j10  <= neg_res(s4_c);
      s5_j11  <= s4_a;
      s5_c1   <= s4_c1;
      s5_c2   <= s4_c2;
      s5_last <= s4_last;
    end
  end

  // Stage 6: scale the adjugate by the inverse determinant.
  logic [PW-1:0] s6_m00, s6_m01, s6_m10, s6_m11;
  logic [RW-1:0] s6_c1, s6_c2;
  logic          s6_bad, s6_last;

  always_ff @(posedge clk) begin
    if (ld[6] && v[5]) begin
      s6_m00  <= PW'(s5_j00) * PW'(s5_inv);
      s6_m01  <= PW'(s5_j01) * PW'(s5_inv);
      s6_m10  <= PW'(s5_j10) * PW'(s5_inv);
      s6_m11  <= PW'(s5_j11) * PW'(s5_inv);
      s6_c1   <= s5_c1;
      s6_c2   <= s5_c2;
      s6_bad  <= s5_bad;
      s6_last <= s5_last;
    end
  end

  // Stage 7: reduce the inverse key entries.
  logic [RW-1:0] s7_i00, s7_i01, s7_i10, s7_i11, s7_c1, s7_c2;
  logic          s7_bad, s7_last;

  always_ff @(posedge clk) begin
    if (ld[7] && v[6]) begin
      s7_i00  <= red_wide(DW'(s6_m00));
      s7_i01  <= red_wide(DW'(s6_m01));
      s7_i10  <= red_wide(DW'(s6_m10));
      s7_i11  <= red_wide(DW'(s6_m11));
      s7_c1   <= s6_c1;
      s7_c2   <= s6_c2;
      s7_bad  <= s6_bad;
      s7_last <= s6_last;
    end
  end

  // Stage 8: matrix times letter vector.
  logic [DW-1:0] s8_q1, s8_q2;
  logic          s8_bad, s8_last;

  always_ff @(posedge clk) begin
    if (ld[8] && v[7]) begin
      s8_q1   <= DW'(s7_i00) * DW'(s7_c1) + DW'(s7_i01) * DW'(s7_c2);
      s8_q2   <= DW'(s7_i10) * DW'(s7_c1) + DW'(s7_i11) * DW'(s7_c2);
      s8_bad  <= s7_bad;
      s8_last <= s7_last;
    end
  end

  // Stage 9: final reduction into the output register.
  plain_t out_item;

  always_ff @(posedge clk) begin
    if (ld[9] && v[8]) begin
      out_item.plain_first        <= s8_bad ? '0 : LETTER_W'(red_wide(s8_q1));
      out_item.plain_second       <= s8_bad ? '0 : LETTER_W'(red_wide(s8_q2));
      out_item.key_not_invertible <= s8_bad;
      out_item.last_pair_out      <= s8_last;
    end
  end

  assign plain.valid = v[NS];
  assign plain.data  = out_item;

  // A singular key never yields letters.
  a_bad_zero : assert property (@(posedge clk) disable iff (rst)
    plain.valid && plain.data.key_not_invertible |->
      plain.data.plain_first == '0 && plain.data.plain_second == '0)
    else $error("nonzero letters with a singular key");

  // Decrypted letters are residues.
  a_out_range : assert property (@(posedge clk) disable iff (rst)
    plain.valid |-> (MODULUS > 32) ||
      (int'(plain.data.plain_first) < MODULUS && int'(plain.data.plain_second) < MODULUS))
    else $error("plaintext letter out of range");

  // The reduced determinant indexes inside the inverse table.
  a_det_range : assert property (@(posedge clk) disable iff (rst)
    v[4] |-> int'(s4_det) < MODULUS)
    else $error("determinant not reduced");

  // A full pipe with a stalled output takes no new item.
  a_full_stall : assert property (@(posedge clk) disable iff (rst)
    (&v) && !plain.ready |-> !cipher.ready)
    else $error("item accepted while pipeline full and stalled");

  // Stage 5, holding an item that cannot move, still holds it next cycle.
  a_hold : assert property (@(posedge clk) disable iff (rst)
    v[5] && !ld[6] |=> v[5])
    else $error("item dropped in stalled stage");

endmodule

`default_nettype wire

>>> dv/hill_cipher_2x2_decrypt_tb.sv
`timescale 1ns / 100ps

module hill_cipher_2x2_decrypt_tb;
  import hc2_pkg::*;

  localparam int ALPHABET = MODULUS_DEF;
  // The pipe is nine stages deep; leave a little margin on top.
  localparam int DRAIN_CYCLES = 14;
  localparam int LONG_HOLD_CYCLES = 80;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_KEY_R0C0;
  logic [LETTER_W-1:0] cfg_data = '0;

  hc2_stream_if #(.T(cipher_t)) cipher_if ();
  hc2_stream_if #(.T(plain_t)) plain_if ();

  hill_cipher_2x2_decrypt u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cipher    (cipher_if),
    .plain     (plain_if)
  );

  // Key as the block should hold it, and the traffic around it.
  logic [LETTER_W-1:0] key_mirror [4];
  cipher_t pending_pairs[$];
  plain_t expected_plain[$];
  int mismatch_count = 0;
  logic bursts_on = 1'b1;
  int hold_requests = 0;
  int holds_served = 0;
  int send_gap = 0;
  int recv_gap = 0;
  int hold_left = 0;
  plain_t want;
  plain_t got;

  always #6 clk = ~clk;

  // Decrypts one pair with the current key: inverse determinant times the adjugate.
  function automatic plain_t decrypt_pair(cipher_t c);
    int a, b, cc, d, det, inv_det, x;
    int n00, n01, n10, n11;
    plain_t r;
    a = int'(key_mirror[REG_KEY_R0C0]) % ALPHABET;
    b = int'(key_mirror[REG_KEY_R0C1]) % ALPHABET;
    cc = int'(key_mirror[REG_KEY_R1C0]) % ALPHABET;
    d = int'(key_mirror[REG_KEY_R1C1]) % ALPHABET;
    det = (a * d - b * cc) % ALPHABET;
    if (det < 0) det += ALPHABET;
    inv_det = 0;
    for (x = 1; x < ALPHABET; x++) begin
      if (inv_det == 0 && (det * x) % ALPHABET == 1) inv_det = x;
    end
    r = '0;
    r.last_pair_out = c.last_pair_in;
    if (inv_det == 0) begin
      r.key_not_invertible = 1'b1;
    end else begin
      n00 = (d * inv_det) % ALPHABET;
      n01 = (((ALPHABET - b) % ALPHABET) * inv_det) % ALPHABET;
      n10 = (((ALPHABET - cc) % ALPHABET) * inv_det) % ALPHABET;
      n11 = (a * inv_det) % ALPHABET;
      r.plain_first = LETTER_W'((n00 * int'(c.cipher_first) +
                                 n01 * int'(c.cipher_second)) % ALPHABET);
      r.plain_second = LETTER_W'((n10 * int'(c.cipher_first) +
                                  n11 * int'(c.cipher_second)) % ALPHABET);
    end
    return r;
  endfunction

  task automatic queue_pair(input int first, input int second, input bit last);
    cipher_t c;
    c.cipher_first = LETTER_W'(first);
    c.cipher_second = LETTER_W'(second);
    c.last_pair_in = last;
    pending_pairs.push_back(c);
  endtask

  // Random messages: mostly well-formed runs ending in a last pair, some stray pairs.
  task automatic queue_messages(input int count);
    int sent, len, i;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 9) == 0) begin
        queue_pair($urandom_range(0, 31), $urandom_range(0, 31), 1'($urandom_range(0, 1)));
        sent++;
      end else begin
        len = $urandom_range(1, 8);
        for (i = 0; i < len; i++) begin
          queue_pair($urandom_range(0, 31), $urandom_range(0, 31), i == len - 1);
        end
        sent += len;
      end
    end
  endtask

  // Waits until every item has been sent and answered, then lets the pipe drain.
  task automatic wait_idle();
    while (pending_pairs.size() != 0 || cipher_if.valid || expected_plain.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LETTER_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    key_mirror[idx] = val;
  endtask

  task automatic load_key(input logic [LETTER_W-1:0] k00, k01, k10, k11);
    write_reg(REG_KEY_R0C0, k00);
    write_reg(REG_KEY_R0C1, k01);
    write_reg(REG_KEY_R1C0, k10);
    write_reg(REG_KEY_R1C1, k11);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Sender: offers queued pairs, records the expected plaintext on each accepted item.
  always @(posedge clk) begin
    if (rst) begin
      cipher_if.valid <= 1'b0;
      cipher_if.data <= '0;
      send_gap = 0;
    end else begin
      if (cipher_if.valid && cipher_if.ready)
        expected_plain.push_back(decrypt_pair(cipher_if.data));
      if (!cipher_if.valid || cipher_if.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          cipher_if.valid <= 1'b0;
        end else if (pending_pairs.size() > 0) begin
          cipher_if.data <= pending_pairs.pop_front();
          cipher_if.valid <= 1'b1;
          if (bursts_on && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 5);
        end else begin
          cipher_if.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each plaintext item and throttles ready.
  always @(posedge clk) begin
    if (rst) begin
      plain_if.ready <= 1'b0;
      recv_gap = 0;
      hold_left = 0;
    end else begin
      if (plain_if.valid && plain_if.ready) begin
        got = plain_if.data;
        if (expected_plain.size() == 0) begin
          $display("%0t: plaintext item with none expected: actual %p", $time, got);
          mismatch_count++;
        end else begin
          want = expected_plain.pop_front();
          if (got.plain_first !== want.plain_first ||
              got.plain_second !== want.plain_second ||
              got.key_not_invertible !== want.key_not_invertible ||
              got.last_pair_out !== want.last_pair_out) begin
            $display("%0t: plaintext mismatch: expected %p actual %p", $time, want, got);
            mismatch_count++;
          end
        end
      end
      if (holds_served != hold_requests) begin
        holds_served++;
        hold_left = LONG_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        plain_if.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        plain_if.ready <= 1'b0;
      end else if (bursts_on && $urandom_range(0, 5) == 0) begin
        recv_gap = $urandom_range(1, 5) - 1;
        plain_if.ready <= 1'b0;
      end else begin
        plain_if.ready <= 1'b1;
      end
    end
  end

  // Run limit.
  initial begin
    #(3_000_000);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int phase;
    // Identity key after reset.
    key_mirror[REG_KEY_R0C0] = 5'd1;
    key_mirror[REG_KEY_R0C1] = 5'd0;
    key_mirror[REG_KEY_R1C0] = 5'd0;
    key_mirror[REG_KEY_R1C1] = 5'd1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Reset key with letter extremes, including values past Z.
    queue_pair(0, 0, 0);
    queue_pair(25, 25, 1);
    queue_pair(31, 31, 0);
    queue_pair(26, 30, 1);
    queue_pair(1, 0, 0);
    wait_idle();

    // A textbook invertible key.
    load_key(5'd3, 5'd3, 5'd2, 5'd5);
    queue_pair(7, 8, 0);
    queue_pair(0, 25, 1);
    queue_pair(31, 0, 1);
    wait_idle();

    // All ones in every key bit: determinant zero.
    load_key(5'd31, 5'd31, 5'd31, 5'd31);
    queue_pair(12, 5, 1);
    queue_pair(25, 0, 0);
    wait_idle();

    // Determinant 13 shares a factor with the alphabet size.
    load_key(5'd13, 5'd0, 5'd0, 5'd1);
    queue_pair(3, 4, 1);
    wait_idle();

    // Swap key: determinant is minus one, so the adjugate terms go negative.
    load_key(5'd0, 5'd1, 5'd1, 5'd0);
    queue_pair(10, 20, 0);
    queue_pair(26, 27, 1);
    wait_idle();

    // Largest letter values on the diagonal.
    load_key(5'd25, 5'd0, 5'd0, 5'd25);
    queue_pair(1, 2, 0);
    queue_pair(30, 29, 1);
    wait_idle();

    // All-zero key.
    load_key(5'd0, 5'd0, 5'd0, 5'd0);
    queue_pair(31, 31, 1);
    wait_idle();

    load_key(5'd2, 5'd1, 5'd1, 5'd1);
    queue_pair(16, 1, 0);
    wait_idle();

    // Random keys and messages; the last phase runs without any idling.
    for (phase = 0; phase < 10; phase++) begin
      load_key($urandom_range(0, 31), $urandom_range(0, 31),
               $urandom_range(0, 31), $urandom_range(0, 31));
      if (phase == 9) bursts_on = 1'b0;
      if (phase == 3) begin
        // Hold the output long enough to back the pipe up into the input.
        hold_requests++;
        queue_messages(60);
      end
      queue_messages(105);
      wait_idle();
    end

    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
